// File: rtl/ols_pkg.sv
// Package for the ordered list store: field widths, capacity, operation and
// status codes, controller command type. No dependencies.
package ols_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic signed [FOUND_W-1:0] FOUND_NONE = '1;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;  // perform the accepted operation and load the result registers
  } ctl_cmd_t;

endpackage

// File: rtl/ols_if.sv
// Handshake channels of the ordered list store: request and response.
// Depends on ols_pkg.
interface ols_req_if;
  logic                          valid;
  logic                          ready;
  logic [ols_pkg::OP_W-1:0]      op;
  logic [ols_pkg::POS_W-1:0]     position;
  logic [ols_pkg::DATA_W-1:0]    item_value;

  modport source (output valid, op, position, item_value, input ready);
  modport sink   (input valid, op, position, item_value, output ready);
endinterface

interface ols_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ols_pkg::STATUS_W-1:0]      status;
  logic [ols_pkg::DATA_W-1:0]        read_value;
  logic signed [ols_pkg::FOUND_W-1:0] found_position;
  logic [ols_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, status, read_value, found_position, entry_count,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, entry_count,
                  output ready);
endinterface

// File: rtl/ordered_list_store_unit.sv
// Top level of the ordered list store: joins the controller and the
// datapath to the request and response channels. Uses ols_pkg and ols_if.
//
//   channel  modport  transaction payload
//   req      sink     op, position, item_value
//   rsp      source   status, read_value, found_position, entry_count
//
// Every operation completes in the cycle its transaction is accepted; the
// result is offered in the next, one operation per clock while rsp does not stall.
// Insert and remove shift all sixteen entry registers at once, and search
// compares all entries in parallel behind a priority encoder.
// A synchronous reset empties the list; entry contents are not cleared.
// While a result waits in the response register, a new request is taken
// only in the cycle that result is taken.
module ordered_list_store_unit (
  input logic        clk,
  input logic        rst,
  ols_req_if.sink    req,
  ols_rsp_if.source  rsp
);
  import ols_pkg::*;

  ctl_cmd_t cmd;

  // The controller owns the handshake on both channels.
  ols_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds the list and the registered response payload.
  ols_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (req.op),
    .position       (req.position),
    .item_value     (req.item_value),
    .status         (rsp.status),
    .read_value     (rsp.read_value),
    .found_position (rsp.found_position),
    .entry_count    (rsp.entry_count)
  );

endmodule

// File: rtl/ols_ctrl.sv
// Controller of the ordered list store: tracks whether the result register
// holds an untaken transaction and issues the execute command. Uses ols_pkg.
module ols_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ols_pkg::ctl_cmd_t cmd
);
  import ols_pkg::*;

  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_HOLD  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign rsp_valid = (state == S_HOLD);
  assign req_ready = (state == S_EMPTY) || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign cmd.exec  = accept;

  always_comb begin
    state_next = state;
    case (state)
      S_EMPTY: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!accept && rsp_ready) state_next = S_EMPTY;
      end
      default: state_next = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid) else $error("accepted request produced no response");
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !req_ready) else $error("input taken over a held result");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("held result dropped");
`endif

endmodule

// File: rtl/ols_dp.sv
// Datapath of the ordered list store: entry registers, count, parallel
// shift and compare logic, result registers. Uses ols_pkg.
module ols_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ols_pkg::ctl_cmd_t                  cmd,
  input  logic [ols_pkg::OP_W-1:0]           op,
  input  logic [ols_pkg::POS_W-1:0]          position,
  input  logic [ols_pkg::DATA_W-1:0]         item_value,
  output logic [ols_pkg::STATUS_W-1:0]       status,
  output logic [ols_pkg::DATA_W-1:0]         read_value,
  output logic signed [ols_pkg::FOUND_W-1:0] found_position,
  output logic [ols_pkg::CNT_W-1:0]          entry_count
);
  import ols_pkg::*;

  logic [DATA_W-1:0]         entries      [CAPACITY];
  logic [DATA_W-1:0]         entries_next [CAPACITY];
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [STATUS_W-1:0]       status_next;
  logic [DATA_W-1:0]         read_next;
  logic signed [FOUND_W-1:0] found_next;
  logic                      pos_ok;
  logic                      is_full;
  logic [CAPACITY-1:0]       hit;

  assign pos_ok  = CNT_W'(position) < count;
  assign is_full = count == CNT_W'(CAPACITY);

  // One comparator per entry; only entries below the count take part.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = (entries[i] == item_value) && (CNT_W'(i) < count);
    end
  end

  always_comb begin
    entries_next = entries;
    count_next   = count;
    status_next  = ST_OK;
    read_next    = '0;
    found_next   = FOUND_NONE;
    case (op)
      OP_APPEND: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          entries_next[count[POS_W-1:0]] = item_value;
          count_next = count + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (!pos_ok) begin
          status_next = ST_BAD_INDEX;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          for (int i = 1; i < CAPACITY; i++) begin
            if (POS_W'(i) > position) entries_next[i] = entries[i-1];
          end
          entries_next[position] = item_value;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!pos_ok) begin
          status_next = ST_BAD_INDEX;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (POS_W'(i) >= position) entries_next[i] = entries[i+1];
          end
          count_next = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          status_next = ST_BAD_INDEX;
        end else begin
          read_next = entries[position];
        end
      end
      OP_SEARCH: begin
        // Priority encoder: the lowest matching entry wins.
        for (int i = CAPACITY - 1; i >= 0; i--) begin
          if (hit[i]) found_next = FOUND_W'(i);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      entries        <= entries_next;
      status         <= status_next;
      read_value     <= read_next;
      found_position <= found_next;
      entry_count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(count)) else $error("count moved without an operation");
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op == OP_APPEND && !is_full) |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the list");
`endif

endmodule

// File: verif/ols_list_checker.sv
`timescale 1ns / 1ps
// Response checker for the ordered list store: watches both channels, predicts
// each response from its own copy of the list and compares. Uses ols_pkg, ols_if.
module ols_list_checker (
  input  logic clk,
  input  logic rst,
  ols_req_if   req,
  ols_rsp_if   rsp,
  output int   errors,
  output int   pending,
  output int   checked
);
  import ols_pkg::*;

  typedef struct packed {
    status_t                    status;
    logic [DATA_W-1:0]          read_value;
    logic signed [FOUND_W-1:0]  found_position;
    logic [CNT_W-1:0]           entry_count;
  } list_rsp_t;

  logic [DATA_W-1:0] list_entries [CAPACITY];
  logic [CNT_W-1:0]  list_fill;
  list_rsp_t         expected_rsps [$];
  int                err_total = 0;
  int                rsp_total = 0;

  task automatic report(input string msg);
    if (err_total < 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    err_total++;
  endtask

  // Applies one operation to the shadow list and returns the response it causes.
  task automatic predict_list_op(input op_t op, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] val, output list_rsp_t r);
    int i;
    logic [CNT_W-1:0] p;
    p                = CNT_W'(pos);
    r.status         = ST_OK;
    r.read_value     = '0;
    r.found_position = FOUND_NONE;
    case (op)
      OP_APPEND: begin
        if (list_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_entries[list_fill] = val;
          list_fill++;
        end
      end
      OP_INSERT: begin
        if (p >= list_fill) begin
          r.status = ST_BAD_INDEX;
        end else if (list_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = int'(list_fill); i > int'(p); i--) list_entries[i] = list_entries[i-1];
          list_entries[p] = val;
          list_fill++;
        end
      end
      OP_REMOVE: begin
        if (p >= list_fill) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (i = int'(p); i + 1 < int'(list_fill); i++) list_entries[i] = list_entries[i+1];
          list_fill--;
        end
      end
      OP_READ: begin
        if (p >= list_fill) r.status = ST_BAD_INDEX;
        else r.read_value = list_entries[p];
      end
      OP_SEARCH: begin
        // Scanning downward leaves the lowest matching index behind.
        for (i = int'(list_fill) - 1; i >= 0; i--) begin
          if (list_entries[i] == val) r.found_position = FOUND_W'(i);
        end
      end
      default: ;
    endcase
    r.entry_count = list_fill;
  endtask

  always @(posedge clk) begin : monitor
    list_rsp_t want;
    if (rst) begin
      list_fill = '0;
      expected_rsps.delete();
    end else begin
      // The response taken at this edge belongs to an earlier request, so it
      // is compared before the request taken at the same edge is predicted.
      if (rsp.valid && rsp.ready) begin
        rsp_total++;
        if (expected_rsps.size() == 0) begin
          report("response with no request outstanding");
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("status expected %0d, got %0d", want.status, rsp.status));
          if (rsp.read_value !== want.read_value)
            report($sformatf("read_value expected %h, got %h",
                             want.read_value, rsp.read_value));
          if (rsp.found_position !== want.found_position)
            report($sformatf("found_position expected %0d, got %0d",
                             want.found_position, rsp.found_position));
          if (rsp.entry_count !== want.entry_count)
            report($sformatf("entry_count expected %0d, got %0d",
                             want.entry_count, rsp.entry_count));
        end
      end
      if (req.valid && req.ready) begin
        predict_list_op(op_t'(req.op), req.position, req.item_value, want);
        expected_rsps.push_back(want);
      end
    end
    errors  <= err_total;
    pending <= expected_rsps.size();
    checked <= rsp_total;
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the ordered list store testbench: clock, reset, request stimulus and
// response back-pressure, verdict. Uses ols_pkg, ols_if and ols_list_checker.
module tb_top;
  import ols_pkg::*;

  // This limit leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BLOCKS = 25;
  localparam int BLOCK_ITEMS   = 40;

  // A small pool of values makes duplicates common, so searches hit often
  // and the lowest-index rule is exercised. Extremes are included.
  localparam logic [DATA_W-1:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
    32'h1234_5678, 32'hDEAD_BEEF, 32'h5A5A_5A5A, 32'h7FFF_FFFF
  };

  // Each random block leans the operation mix one way so that the list
  // swings between empty and full instead of hovering at one depth.
  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} list_mode_t;

  logic clk = 1'b0;
  logic rst;
  bit   no_idle;
  int   cycles = 0;
  int   op_tally [5];
  int   errors;
  int   pending;
  int   checked;

  ols_req_if req_ch ();
  ols_rsp_if rsp_ch ();

  ordered_list_store_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ols_list_checker list_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The response side stalls in about a third of the cycles, except during
  // the quiet stretch and the final drain, where it accepts every cycle.
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else if (no_idle) rsp_ch.ready <= 1'b1;
    else rsp_ch.ready <= ($urandom_range(0, 99) >= 34);
  end

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 60) return VALUE_POOL[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Presents one request transaction and returns at the edge where it is
  // accepted. Idle cycles are inserted in front of it at random. The valid
  // line is left high on return, so a back-to-back request keeps it high
  // without a drop inside the same time step.
  task automatic send_op(input op_t op, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val);
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.position   <= pos;
    req_ch.item_value <= val;
    op_tally[int'(op)]++;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted response has arrived. The
  // checker's count is registered, so it is read only after a wait on the clock.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    list_mode_t       mode;
    op_t              op;
    logic [POS_W-1:0] pos;
    int               roll;

    rst               <= 1'b1;
    no_idle           <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_APPEND;
    req_ch.position   <= '0;
    req_ch.item_value <= '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. On the empty list: a search answers none, and read,
    // insert and remove all report a bad index, the first two at position zero.
    send_op(OP_SEARCH, 4'd0, 32'h0000_0000);
    send_op(OP_READ, 4'd0, 32'h0000_0000);
    send_op(OP_INSERT, 4'd0, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, 4'd15, 32'h0000_0000);

    // Fill the list to capacity; the pool repeats, so duplicates are stored.
    for (int i = 0; i < CAPACITY; i++) send_op(OP_APPEND, POS_W'(i), VALUE_POOL[i % 8]);

    // Full list: append and a well-placed insert are both refused as full.
    send_op(OP_APPEND, 4'd0, 32'h0000_0001);
    send_op(OP_INSERT, 4'd15, 32'h0000_0002);
    send_op(OP_READ, 4'd15, 32'h0000_0000);
    // Search for a duplicated value must return the lower index.
    send_op(OP_SEARCH, 4'd0, VALUE_POOL[3]);
    send_op(OP_REMOVE, 4'd0, 32'h0000_0000);
    send_op(OP_REMOVE, 4'd14, 32'h0000_0000);
    // Inserting at the position equal to the count is rejected as a bad index.
    send_op(OP_INSERT, 4'd14, 32'hA5A5_A5A5);
    send_op(OP_INSERT, 4'd13, 32'hFFFF_FFFF);
    send_op(OP_SEARCH, 4'd0, 32'h0000_0000);

    // Random part, in blocks with a biased operation mix.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      mode = list_mode_t'($urandom_range(0, 2));
      // Once in the run the sender holds off until the checker is empty.
      if (blk == 10) drain_results();
      no_idle <= (blk >= 14 && blk < 18);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          MODE_GROW: begin
            op = roll < 40 ? OP_APPEND : roll < 70 ? OP_INSERT :
                 roll < 80 ? OP_READ   : roll < 95 ? OP_SEARCH : OP_REMOVE;
          end
          MODE_SHRINK: begin
            op = roll < 50 ? OP_REMOVE : roll < 65 ? OP_READ   :
                 roll < 80 ? OP_SEARCH : roll < 90 ? OP_APPEND : OP_INSERT;
          end
          default: begin
            op = roll < 20 ? OP_APPEND : roll < 40 ? OP_INSERT :
                 roll < 60 ? OP_REMOVE : roll < 80 ? OP_READ   : OP_SEARCH;
          end
        endcase
        // Positions span the whole field, so bad indices keep turning up;
        // while shrinking, half of them stay low so that removals land.
        if (mode == MODE_SHRINK && $urandom_range(0, 1) == 1)
          pos = POS_W'($urandom_range(0, 3));
        else
          pos = POS_W'($urandom_range(0, CAPACITY - 1));
        send_op(op, pos, pick_value());
      end
    end

    // End of stimulus: accept every response, then keep the clock running so that
    // a stray response would still be caught.
    no_idle <= 1'b1;
    drain_results();
    repeat (8) @(posedge clk);

    $display("Summary: %0d list operations (append %0d, insert %0d, remove %0d, read %0d, %s",
             op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3] + op_tally[4],
             op_tally[0], op_tally[1], op_tally[2], op_tally[3],
             $sformatf("search %0d), %0d responses checked.", op_tally[4], checked));
    $display("Covered empty-list, full-list and bad-index cases under random stalls.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
